// ===== rtl/core/qslerp_pkg.sv =====
// Shared constants, table and types for the quaternion slerp pipeline.
// Used by qslerp_weights and quaternion_slerp; depends on nothing else.
package qslerp_pkg;

  // Number of one-bit steps of the square root, from 4^30 down to 4^0.
  localparam int ROOT_STEPS = 31;
  // Number of quotient bits produced by the weight divider.
  localparam int DIV_STEPS = 32;

  // Inverse CORDIC gain in Q.30.
  localparam logic [31:0] KINV_Q30 = 32'd652032874;

  // One in Q1.15 for the interpolation weight.
  localparam logic [15:0] T_ONE = 16'd32768;

  // Interpolation modes.
  localparam logic MODE_SLERP = 1'b0;

  // Configuration register indexes.
  localparam logic REG_MODE = 1'b0;
  localparam logic REG_NEAR = 1'b1;

  // atan(2^-i) in Q.30.
  localparam logic [31:0] ATAN_TAB [0:31] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
    32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
    32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
    32'h00000001, 32'h00000000
  };

  // Per-item control that travels with the weight computation.
  typedef struct packed {
    logic        sph;
    logic [15:0] t;
  } side_t;

  // Register stages from the weight unit's input to its k0/k1 outputs.
  function automatic int weight_lat(input int steps);
    return ROOT_STEPS + DIV_STEPS + 2 * steps + 7;
  endfunction

endpackage

// ===== rtl/core/qslerp_weights.sv =====
// Pipelined interpolation weights: square root, CORDIC atan2, two CORDIC sines
// and two restoring dividers. Depends on qslerp_pkg.
module qslerp_weights #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                     clk,
  input  qslerp_pkg::side_t        side_in,
  input  logic [29:0]              dot,
  output logic signed [32:0]       k0,
  output logic signed [32:0]       k1
);

  localparam int NS = CORDIC_STEPS;
  localparam int RS = qslerp_pkg::ROOT_STEPS;
  localparam int DS = qslerp_pkg::DIV_STEPS;

  // Square of the cosine.
  qslerp_pkg::side_t side_sq;
  logic [29:0]       dot_sq;
  logic [59:0]       sq;

  always_ff @(posedge clk) begin
    side_sq <= side_in;
    dot_sq  <= dot;
    sq      <= dot * dot;
  end

  // Integer square root of 2^60 - cos^2, one result bit per stage.
  logic [60:0]       rt_v    [0:RS];
  logic [61:0]       rt_r    [0:RS];
  logic [29:0]       rt_dot  [0:RS];
  qslerp_pkg::side_t rt_side [0:RS];

  always_ff @(posedge clk) begin
    rt_v[0]    <= {1'b1, 60'd0} - {1'b0, sq};
    rt_r[0]    <= '0;
    rt_dot[0]  <= dot_sq;
    rt_side[0] <= side_sq;
  end

  for (genvar j = 0; j < RS; j++) begin : g_root
    localparam logic [61:0] BITV = 62'd1 << (2 * (RS - 1 - j));
    logic [61:0] trial;
    assign trial = rt_r[j] + BITV;
    always_ff @(posedge clk) begin
      if ({1'b0, rt_v[j]} >= trial) begin
        rt_v[j+1] <= rt_v[j] - trial[60:0];
        rt_r[j+1] <= (rt_r[j] >> 1) + BITV;
      end else begin
        rt_v[j+1] <= rt_v[j];
        rt_r[j+1] <= rt_r[j] >> 1;
      end
      rt_dot[j+1]  <= rt_dot[j];
      rt_side[j+1] <= rt_side[j];
    end
  end

  // CORDIC vectoring: theta = atan2(sin, cos).
  logic signed [33:0] vx     [0:NS];
  logic signed [33:0] vy     [0:NS];
  logic signed [32:0] vz     [0:NS];
  logic [30:0]        v_s    [0:NS];
  qslerp_pkg::side_t  v_side [0:NS];

  always_ff @(posedge clk) begin
    vx[0]     <= {4'b0, rt_dot[RS]};
    vy[0]     <= {3'b0, rt_r[RS][30:0]};
    vz[0]     <= '0;
    v_s[0]    <= rt_r[RS][30:0];
    v_side[0] <= rt_side[RS];
  end

  for (genvar i = 0; i < NS; i++) begin : g_vec
    localparam logic signed [32:0] ANG = $signed(33'(qslerp_pkg::ATAN_TAB[i]));
    always_ff @(posedge clk) begin
      if (vy[i] >= 0) begin
        vx[i+1] <= vx[i] + (vy[i] >>> i);
        vy[i+1] <= vy[i] - (vx[i] >>> i);
        vz[i+1] <= vz[i] + ANG;
      end else begin
        vx[i+1] <= vx[i] - (vy[i] >>> i);
        vy[i+1] <= vy[i] + (vx[i] >>> i);
        vz[i+1] <= vz[i] - ANG;
      end
      v_s[i+1]    <= v_s[i];
      v_side[i+1] <= v_side[i];
    end
  end

  // Angle products theta*(1-t) and theta*t.
  logic signed [49:0] pr [0:1];
  logic [30:0]        pr_s;
  qslerp_pkg::side_t  pr_side;

  always_ff @(posedge clk) begin
    pr[0]   <= vz[NS] * $signed({1'b0, qslerp_pkg::T_ONE - v_side[NS].t});
    pr[1]   <= vz[NS] * $signed({1'b0, v_side[NS].t});
    pr_s    <= v_s[NS];
    pr_side <= v_side[NS];
  end

  // Two CORDIC rotations for the sines, one lane each.
  logic signed [33:0] rx     [0:1][0:NS];
  logic signed [33:0] ry     [0:1][0:NS];
  logic signed [34:0] rz     [0:1][0:NS];
  logic [30:0]        r_s    [0:NS];
  qslerp_pkg::side_t  r_side [0:NS];

  always_ff @(posedge clk) begin
    r_s[0]    <= pr_s;
    r_side[0] <= pr_side;
  end

  for (genvar ln = 0; ln < 2; ln++) begin : g_rot_lane
    always_ff @(posedge clk) begin
      rx[ln][0] <= 34'(qslerp_pkg::KINV_Q30);
      ry[ln][0] <= '0;
      rz[ln][0] <= $signed(pr[ln][49:15]);
    end
    for (genvar i = 0; i < NS; i++) begin : g_rot
      localparam logic signed [34:0] ANG = $signed(35'(qslerp_pkg::ATAN_TAB[i]));
      always_ff @(posedge clk) begin
        if (rz[ln][i] >= 0) begin
          rx[ln][i+1] <= rx[ln][i] - (ry[ln][i] >>> i);
          ry[ln][i+1] <= ry[ln][i] + (rx[ln][i] >>> i);
          rz[ln][i+1] <= rz[ln][i] - ANG;
        end else begin
          rx[ln][i+1] <= rx[ln][i] + (ry[ln][i] >>> i);
          ry[ln][i+1] <= ry[ln][i] - (rx[ln][i] >>> i);
          rz[ln][i+1] <= rz[ln][i] + ANG;
        end
      end
    end
  end

  for (genvar i = 0; i < NS; i++) begin : g_rot_side
    always_ff @(posedge clk) begin
      r_s[i+1]    <= r_s[i];
      r_side[i+1] <= r_side[i];
    end
  end

  // Restoring dividers: k = sine * 2^30 / sin(theta), truncated, clamped to 2^31.
  logic [63:0]       dv_rem  [0:1][0:DS];
  logic [31:0]       dv_q    [0:1][0:DS];
  logic              dv_neg  [0:1][0:DS];
  logic              dv_ovf  [0:1][0:DS];
  logic [30:0]       dv_s    [0:DS];
  qslerp_pkg::side_t dv_side [0:DS];
  logic signed [32:0] kd     [0:1];

  always_ff @(posedge clk) begin
    dv_s[0]    <= r_s[NS];
    dv_side[0] <= r_side[NS];
  end

  for (genvar ln = 0; ln < 2; ln++) begin : g_div_lane
    logic [33:0] mag;
    logic [32:0] kmag;
    assign mag = (ry[ln][NS] < 0) ? 34'(-ry[ln][NS]) : 34'(ry[ln][NS]);

    // A magnitude of four times the divisor or more already gives a quotient of 2^32 or more.
    always_ff @(posedge clk) begin
      dv_rem[ln][0] <= 64'(mag) << 30;
      dv_q[ln][0]   <= '0;
      dv_neg[ln][0] <= ry[ln][NS] < 0;
      dv_ovf[ln][0] <= {1'b0, mag} >= {2'b0, r_s[NS], 2'b0};
    end

    for (genvar j = 0; j < DS; j++) begin : g_div
      localparam int SH = DS - 1 - j;
      logic [63:0] dsub;
      assign dsub = 64'(dv_s[j]) << SH;
      always_ff @(posedge clk) begin
        if (dv_rem[ln][j] >= dsub) begin
          dv_rem[ln][j+1] <= dv_rem[ln][j] - dsub;
          dv_q[ln][j+1]   <= dv_q[ln][j] | (32'd1 << SH);
        end else begin
          dv_rem[ln][j+1] <= dv_rem[ln][j];
          dv_q[ln][j+1]   <= dv_q[ln][j];
        end
        dv_neg[ln][j+1] <= dv_neg[ln][j];
        dv_ovf[ln][j+1] <= dv_ovf[ln][j];
      end
    end

    always_comb begin
      if (dv_ovf[ln][DS] || dv_q[ln][DS] > 32'h8000_0000) begin
        kmag = 33'h0_8000_0000;
      end else begin
        kmag = {1'b0, dv_q[ln][DS]};
      end
      kd[ln] = dv_neg[ln][DS] ? -$signed(kmag) : $signed(kmag);
    end
  end

  for (genvar j = 0; j < DS; j++) begin : g_div_side
    always_ff @(posedge clk) begin
      dv_s[j+1]    <= dv_s[j];
      dv_side[j+1] <= dv_side[j];
    end
  end

  // Pick the spherical or the linear weights.
  logic [15:0] t_end;
  assign t_end = dv_side[DS].t;

  always_ff @(posedge clk) begin
    if (dv_side[DS].sph) begin
      k0 <= kd[0];
      k1 <= kd[1];
    end else begin
      k0 <= $signed({2'b0, qslerp_pkg::T_ONE - t_end, 15'd0});
      k1 <= $signed({2'b0, t_end, 15'd0});
    end
  end

endmodule

// ===== rtl/core/quaternion_slerp.sv =====
// Top level of the fixed-point quaternion slerp pipeline.
// Depends on qslerp_pkg and qslerp_weights.
//
// Usage. A transaction is taken at each rising edge where start is high and busy
// is low; busy is high only while rst is held, so one item may enter every cycle.
// The item is q1 and q2 (Q2.14 at COMP_BITS = 16) and the weight t_weight (Q1.15,
// values above one are treated as one). Each result appears on r_x..r_w and
// saturated for exactly one cycle with done high; the receiver cannot stall.
// The pipeline depth comes from the 31-step square root, the two CORDIC
// passes and the 32-bit dividers, each one register stage per step.
// Throughput is one transaction per cycle; results leave in input order.
// The configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is
// always ready. Index 0 writes interp_mode from cfg_data[0], index 1 writes
// near_limit. Write it only while no transaction is in flight.
// Synchronous reset clears the valid bits and sets interp_mode to spherical
// and near_limit to 16; anything in flight is dropped.
module quaternion_slerp #(
  parameter int COMP_BITS    = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic signed [COMP_BITS-1:0] q1_x,
  input  logic signed [COMP_BITS-1:0] q1_y,
  input  logic signed [COMP_BITS-1:0] q1_z,
  input  logic signed [COMP_BITS-1:0] q1_w,
  input  logic signed [COMP_BITS-1:0] q2_x,
  input  logic signed [COMP_BITS-1:0] q2_y,
  input  logic signed [COMP_BITS-1:0] q2_z,
  input  logic signed [COMP_BITS-1:0] q2_w,
  input  logic [15:0]                 t_weight,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic                        cfg_index,
  input  logic [14:0]                 cfg_data,
  output logic                        done,
  output logic signed [COMP_BITS-1:0] r_x,
  output logic signed [COMP_BITS-1:0] r_y,
  output logic signed [COMP_BITS-1:0] r_z,
  output logic signed [COMP_BITS-1:0] r_w,
  output logic                        saturated
);

  localparam int CB      = COMP_BITS;
  localparam int FRAC    = CB - 2;
  localparam int EXP     = 2 * FRAC;
  localparam int DOT_SHL = (EXP < 30) ? 30 - EXP : 0;
  localparam int DOT_SHR = (EXP > 30) ? EXP - 30 : 0;
  localparam int PW      = 2 * CB;
  localparam int TW      = (PW > 36) ? PW : 36;
  localparam int NEAR_SH = 30 - FRAC;
  localparam int WL      = qslerp_pkg::weight_lat(CORDIC_STEPS);
  localparam int LAT     = WL + 6;

  typedef logic signed [CB+34:0] acc_t;

  localparam acc_t RMAX = (acc_t'(1) <<< (CB - 1)) - acc_t'(1);
  localparam acc_t RMIN = -RMAX - acc_t'(1);
  localparam logic signed [CB-1:0] CMAX = {1'b0, {(CB-1){1'b1}}};
  localparam logic signed [CB-1:0] CMIN = {1'b1, {(CB-1){1'b0}}};

  typedef struct packed {
    logic                sph;
    logic [3:0][CB-1:0]  a;
    logic [3:0][CB:0]    b;
  } line_t;

  // Configuration registers.
  logic        interp_mode;
  logic [14:0] near_limit;

  assign cfg_ready = 1'b1;
  assign busy      = rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      interp_mode <= qslerp_pkg::MODE_SLERP;
      near_limit  <= 15'd16;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        qslerp_pkg::REG_MODE: interp_mode <= cfg_data[0];
        qslerp_pkg::REG_NEAR: near_limit  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stage A: capture the transaction and clamp the weight to one.
  logic               a_v;
  logic [3:0][CB-1:0] a_q1;
  logic [3:0][CB-1:0] a_q2;
  logic [15:0]        a_t;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
    end else begin
      a_v <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    a_q1 <= {q1_w, q1_z, q1_y, q1_x};
    a_q2 <= {q2_w, q2_z, q2_y, q2_x};
    a_t  <= (t_weight > qslerp_pkg::T_ONE) ? qslerp_pkg::T_ONE : t_weight;
  end

  // Stage B: four component products, scaled to Q.30.
  logic               b_v;
  logic signed [35:0] b_term [0:3];
  logic [3:0][CB-1:0] b_q1;
  logic [3:0][CB-1:0] b_q2;
  logic [15:0]        b_t;

  for (genvar i = 0; i < 4; i++) begin : g_prod
    logic signed [PW-1:0] prod;
    logic signed [TW-1:0] wide;
    assign prod = $signed(a_q1[i]) * $signed(a_q2[i]);
    assign wide = (TW'(prod) <<< DOT_SHL) >>> DOT_SHR;
    always_ff @(posedge clk) begin
      b_term[i] <= wide[35:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_v <= 1'b0;
    end else begin
      b_v <= a_v;
    end
  end

  always_ff @(posedge clk) begin
    b_q1 <= a_q1;
    b_q2 <= a_q2;
    b_t  <= a_t;
  end

  // Stage C: the dot product.
  logic               c_v;
  logic signed [35:0] c_dot;
  logic [3:0][CB-1:0] c_q1;
  logic [3:0][CB-1:0] c_q2;
  logic [15:0]        c_t;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_v <= 1'b0;
    end else begin
      c_v <= b_v;
    end
  end

  always_ff @(posedge clk) begin
    c_dot <= b_term[0] + b_term[1] + b_term[2] + b_term[3];
    c_q1  <= b_q1;
    c_q2  <= b_q2;
    c_t   <= b_t;
  end

  // Stage D: take the short way round by flipping q2 when the cosine is
  // negative, then decide whether the spherical weights are needed.
  logic               d_neg;
  logic               d_sph;
  logic signed [35:0] d_abs;
  logic signed [35:0] d_gap;
  logic signed [35:0] d_thr;
  logic [3:0][CB:0]   d_b;

  always_comb begin
    d_neg = c_dot < 0;
    d_abs = d_neg ? -c_dot : c_dot;
    d_gap = 36'sd1073741824 - d_abs;
    d_thr = $signed(36'(near_limit) << NEAR_SH);
    d_sph = (interp_mode == qslerp_pkg::MODE_SLERP) && (d_gap > d_thr);
    for (int i = 0; i < 4; i++) begin
      d_b[i] = d_neg ? -{c_q2[i][CB-1], c_q2[i]} : {c_q2[i][CB-1], c_q2[i]};
    end
  end

  // Delay line that keeps the components beside the weight unit.
  line_t             line   [0:WL];
  logic              line_v [0:WL];
  logic [29:0]       w_dot;
  qslerp_pkg::side_t w_side;

  always_ff @(posedge clk) begin
    line[0].sph <= d_sph;
    line[0].a   <= c_q1;
    line[0].b   <= d_b;
    w_dot       <= d_abs[29:0];
    w_side.sph  <= d_sph;
    w_side.t    <= c_t;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_v[0] <= 1'b0;
    end else begin
      line_v[0] <= c_v;
    end
  end

  for (genvar j = 0; j < WL; j++) begin : g_line
    always_ff @(posedge clk) begin
      line[j+1] <= line[j];
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        line_v[j+1] <= 1'b0;
      end else begin
        line_v[j+1] <= line_v[j];
      end
    end
  end

  logic signed [32:0] k0;
  logic signed [32:0] k1;

  qslerp_weights #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_weights (
    .clk     (clk),
    .side_in (w_side),
    .dot     (w_dot),
    .k0      (k0),
    .k1      (k1)
  );

  // Stage E: weight each quaternion. The products take the full accumulator
  // width from the assignment.
  logic e_v;
  acc_t e_p0 [0:3];
  acc_t e_p1 [0:3];

  always_ff @(posedge clk) begin
    if (rst) begin
      e_v <= 1'b0;
    end else begin
      e_v <= line_v[WL];
    end
  end

  for (genvar i = 0; i < 4; i++) begin : g_blend
    always_ff @(posedge clk) begin
      e_p0[i] <= $signed(line[WL].a[i]) * k0;
      e_p1[i] <= $signed(line[WL].b[i]) * k1;
    end
  end

  // Stage F: round, sum and saturate into the output registers.
  acc_t                  f_acc [0:3];
  acc_t                  f_res [0:3];
  logic signed [CB-1:0]  f_out [0:3];
  logic [3:0]            f_clip;
  logic signed [CB-1:0]  r_out [0:3];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      f_acc[i] = (e_p0[i] >>> 1) + (e_p1[i] >>> 1) + (acc_t'(1) <<< 28);
      f_res[i] = f_acc[i] >>> 29;
      if (f_res[i] > RMAX) begin
        f_out[i]  = CMAX;
        f_clip[i] = 1'b1;
      end else if (f_res[i] < RMIN) begin
        f_out[i]  = CMIN;
        f_clip[i] = 1'b1;
      end else begin
        f_out[i]  = f_res[i][CB-1:0];
        f_clip[i] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= e_v;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      r_out[i] <= f_out[i];
    end
    saturated <= |f_clip;
  end

  assign r_x = r_out[0];
  assign r_y = r_out[1];
  assign r_z = r_out[2];
  assign r_w = r_out[3];

`ifndef SYNTH
  // Every accepted transaction comes out after the fixed pipeline depth.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##LAT done)
    else $error("result missing at the pipeline latency");

  // A clipped result has at least one component on a rail.
  a_sat_rail: assert property (@(posedge clk) disable iff (rst)
    done && saturated |->
      (r_x == CMAX || r_x == CMIN || r_y == CMAX || r_y == CMIN ||
       r_z == CMAX || r_z == CMIN || r_w == CMAX || r_w == CMIN))
    else $error("saturated flag without a clipped component");

  // Linear weights meeting their components must sum to one in Q.30.
  a_lin_sum: assert property (@(posedge clk) disable iff (rst)
    line_v[WL] && !line[WL].sph |-> (k0 + k1) == 33'sh040000000)
    else $error("linear weights misaligned with their transaction");
`endif

endmodule
